FILE: rtl/idt_pkg.sv
package idt_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int ACTION_W = 2;
  localparam int NAME_W   = 16;
  localparam int TYPE_W   = 8;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int HELD_W   = 7;
  localparam int ENTRY_W  = NAME_W + TYPE_W;

  localparam logic [TYPE_W-1:0] TYPE_CLASS_MASK = 8'hF0;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENTER  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOCATE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTF  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADIX = 3'd4;

  typedef struct packed {
    logic                load;
    logic                start;
    logic                step;
    logic                clear;
    logic                append;
    logic                dec;
    logic                hit;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                res_load;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                cnt_zero;
    logic                full;
    logic                bad_idx;
    logic                match;
    logic                scan_end;
  } sts_t;

endpackage

FILE: rtl/idt_ctrl.sv
module idt_ctrl
  import idt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  output logic result_valid,
  input  logic result_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_vld;
  logic       out_vld_next;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = out_vld;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (sts.act)
          ACT_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_next     = S_DONE;
          end
          ACT_ENTER: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_next     = S_DONE;
            end else begin
              cmd.start  = 1'b1;
              state_next = S_SCAN;
            end
          end
          ACT_LOCATE: begin
            cmd.start  = 1'b1;
            state_next = S_SCAN;
          end
          ACT_REMOVE: begin
            if (sts.cnt_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_OK;
              state_next     = S_DONE;
            end else if (sts.bad_idx) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADIX;
              state_next     = S_DONE;
            end else begin
              cmd.start  = 1'b1;
              state_next = S_SHIFT;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.set_status = 1'b1;
          if (sts.act == ACT_ENTER) begin
            cmd.status = ST_DUPL;
          end else begin
            cmd.status = ST_OK;
            cmd.hit    = 1'b1;
          end
          state_next = S_DONE;
        end else if (sts.scan_end) begin
          cmd.set_status = 1'b1;
          if (sts.act == ACT_ENTER) begin
            cmd.status = ST_OK;
            cmd.append = 1'b1;
          end else begin
            cmd.status = ST_NOTF;
          end
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.scan_end) begin
          cmd.dec        = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_vld || result_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_next = out_vld;
    if (cmd.res_load) begin
      out_vld_next = 1'b1;
    end else if (result_ready) begin
      out_vld_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      out_vld <= out_vld_next;
    end
  end

endmodule

FILE: rtl/idt_datapath.sv
module idt_datapath
  import idt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ACTION_W-1:0] action,
  input  logic [NAME_W-1:0]   entry_name,
  input  logic [TYPE_W-1:0]   entry_type,
  input  logic [SLOT_W-1:0]   slot_index,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   found_slot,
  output logic [HELD_W-1:0]   entries_held,
  input  cmd_t                cmd,
  output sts_t                sts
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rdata;
  logic [ACTION_W-1:0] act;
  logic [ENTRY_W-1:0]  want;
  logic [SLOT_W-1:0]   slot;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    idx;
  logic                pend;
  logic [IDX_W-1:0]    pidx;
  logic [IDX_W-1:0]    found;
  logic [STATUS_W-1:0] st;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_found;
  logic [HELD_W-1:0]   res_held;

  logic                rd_en;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic                name_eq;
  logic                class_eq;

  assign rd_en = cmd.step && (idx < cnt);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt[IDX_W-1:0];
    wr_data = want;
    if (cmd.append) begin
      wr_en = 1'b1;
    end else if (cmd.step && pend && (act == ACT_REMOVE)) begin
      wr_en   = 1'b1;
      wr_addr = pidx - IDX_W'(1);
      wr_data = rdata;
    end
  end

  assign name_eq  = (rdata[ENTRY_W-1:TYPE_W] == want[ENTRY_W-1:TYPE_W]);
  assign class_eq = ((rdata[TYPE_W-1:0] & TYPE_CLASS_MASK) ==
                     (want[TYPE_W-1:0] & TYPE_CLASS_MASK));

  always_comb begin
    sts.act      = act;
    sts.cnt_zero = (cnt == '0);
    sts.full     = (cnt >= CNT_W'(DEPTH));
    sts.bad_idx  = (CMP_W'(slot) >= CMP_W'(cnt));
    sts.scan_end = (idx == cnt) && !pend;
    sts.match    = pend && name_eq &&
                   ((act == ACT_ENTER) ? (rdata[TYPE_W-1:0] == want[TYPE_W-1:0])
                                       : class_eq);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[idx[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= action;
      want  <= {entry_name, entry_type};
      slot  <= slot_index;
      found <= '0;
    end else if (cmd.append) begin
      found <= cnt[IDX_W-1:0];
    end else if (cmd.hit) begin
      found <= pidx;
    end
    if (rd_en) begin
      pidx <= idx[IDX_W-1:0];
    end
    if (cmd.set_status) begin
      st <= cmd.status;
    end
    if (cmd.res_load) begin
      res_status <= st;
      res_found  <= SLOT_W'(found);
      res_held   <= HELD_W'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      idx  <= '0;
      pend <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt <= '0;
      end else if (cmd.append) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.dec) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (cmd.start) begin
        idx  <= (act == ACT_REMOVE) ? CNT_W'(slot) + CNT_W'(1) : '0;
        pend <= 1'b0;
      end else if (cmd.step) begin
        pend <= rd_en;
        if (rd_en) begin
          idx <= idx + CNT_W'(1);
        end
      end
    end
  end

  assign status       = res_status;
  assign found_slot   = res_found;
  assign entries_held = res_held;

endmodule

FILE: rtl/identifier_table.sv
// Identifier table: holds up to DEPTH entries, each a 16-bit name with an
// 8-bit type, packed into slots 0 to entries_held-1 of a single-port-read
// memory.
// The item channel (item_valid/item_ready) carries one action per
// transaction; the result channel (result_valid/result_ready) returns exactly
// one result transaction for it: status, found_slot and entries_held.
// One transaction is processed at a time. Clear and the early exits (full,
// remove from an empty table, bad index) go from the decide state straight
// to the result. Enter and locate read one stored entry per cycle, and
// remove shifts one entry per cycle, from slot_index + 1 up to the last
// entry held. The memory read port sets this pace.
// The result is held in an output register; while the receiver stalls, the
// block finishes the current transaction and then waits, and item_ready
// stays low until the result has been loaded.
// Reset empties the table at once; the memory itself is not cleared, and
// no entry is read before it has been written.
module identifier_table
  import idt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic [NAME_W-1:0]   entry_name,
  input  logic [TYPE_W-1:0]   entry_type,
  input  logic [SLOT_W-1:0]   slot_index,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   found_slot,
  output logic [HELD_W-1:0]   entries_held
);

  cmd_t cmd;
  sts_t sts;

  idt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  idt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .entry_name   (entry_name),
    .entry_type   (entry_type),
    .slot_index   (slot_index),
    .status       (status),
    .found_slot   (found_slot),
    .entries_held (entries_held),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
